FILE: rtl/core/bfhr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfhr_pkg;

  // Integral store geometry.
  localparam int MAX_IMAGE_WIDTH  = 256;
  localparam int MAX_IMAGE_HEIGHT = 256;
  localparam int COL_BITS    = $clog2(MAX_IMAGE_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_IMAGE_HEIGHT);
  localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
  localparam int STORE_DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int WORD_W      = 24;

  // Datapath widths.
  localparam int CW   = 17;  // signed image coordinate
  localparam int BW   = 27;  // signed box integral accumulator
  localparam int DW   = 28;  // signed Dxx, Dyy, Dxy
  localparam int PW   = 56;  // signed product of two D terms
  localparam int NW   = 64;  // signed determinant numerator
  localparam int DENW = 40;  // 100 * filter^4
  localparam int QW   = 80;  // dividend and quotient
  localparam int RESP_W = 48;

  // Sequencer counts.
  localparam int READS   = 32;
  localparam int RCNT_W  = 6;
  localparam int DCNT_W  = 7;

  localparam logic [RESP_W-1:0] RESP_MAX = {1'b0, {(RESP_W-1){1'b1}}};
  localparam logic [RESP_W-1:0] RESP_MIN = {1'b1, {(RESP_W-1){1'b0}}};

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

  // Operation codes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_MUL_A,
    S_MUL_B,
    S_SCALE,
    S_NUM,
    S_DIV,
    S_SAT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/bfhr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bfhr_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  row_index;
  logic [7:0]  col_index;
  logic [23:0] integral_value;

  modport source (output valid, output operation, output row_index, output col_index,
                  output integral_value, input ready);
  modport sink (input valid, input operation, input row_index, input col_index,
                input integral_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bfhr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bfhr_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] response;
  logic        laplacian_sign;

  modport source (output valid, output response, output laplacian_sign, input ready);
  modport sink (input valid, input response, input laplacian_sign, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bfhr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bfhr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/box_filter_hessian_response_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Transaction
// in_ch     in   load word (operation 0) or compute sample (operation 1)
// out_ch    out  response (Q16, saturated) and Laplacian sign, one per compute
// cfg_*     in   register write: filter size, sample step, image width, height
//
// A load leaves the control idle; the input is ready again on the next cycle.
// A compute holds the input until its result is handed off, so no new compute or load is
// taken before then: one setup state, the 32 integral memory reads through its single read
// port, two multiply states, a scale and a numerator state, a one-bit-per-cycle divider,
// one saturation state and one handoff state; a zero denominator skips the divider and
// the saturation state.
// Reset (rst_n low, synchronous) clears control and configuration; the memory
// holds no reset value. A finished result waits in the output register while loads
// and the next compute are still taken; that compute holds in its handoff cycle until
// the output register is free.

module box_filter_hessian_response_core (
  input  logic                              clk,
  input  logic                              rst_n,
  bfhr_in_if.sink                           in_ch,
  bfhr_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [bfhr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfhr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bfhr_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0] filter_size_r;
  logic [5:0] sample_step_r;
  logic [8:0] image_width_r;
  logic [8:0] image_height_r;

  logic [7:0]  row_r, col_r;
  coord_t      pos_r_r, pos_c_r;
  logic [7:0]  lobe_r, half_r;
  logic [15:0] w2_r;
  logic [31:0] w4_r;

  logic [RCNT_W-1:0] cnt_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic              p_valid_r, p_zero_r;
  logic [2:0]        p_box_r;
  logic [1:0]        p_corner_r;
  logic signed [BW-1:0] box_acc_r;
  logic signed [DW-1:0] dxx_r, dyy_r, dxy_r;

  logic signed [PW-1:0] pa_r, pb_r;
  logic signed [NW-1:0] t1_r, t2_r;
  logic [DENW-1:0]      den_r;
  logic [QW-1:0]        dvd_r;
  logic [DENW-1:0]      rem_r;
  logic                 neg_r, lap_r;
  logic [RESP_W-1:0]    res_r;

  logic              out_valid_r;
  logic [RESP_W-1:0] out_resp_r;
  logic              out_lap_r;

  logic in_fire, out_free;

  assign in_ch.ready           = (state_r == S_IDLE);
  assign in_fire               = in_ch.valid && in_ch.ready;
  assign out_free              = !out_valid_r || out_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.response       = out_resp_r;
  assign out_ch.laplacian_sign = out_lap_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_size_r  <= 8'd9;
      sample_step_r  <= 6'd2;
      image_width_r  <= 9'd256;
      image_height_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_SIZE:  filter_size_r  <= cfg_data[7:0];
        CFG_SAMPLE_STEP:  sample_step_r  <= cfg_data[5:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Integral memory: loads write, the box sequencer reads.
  logic                 ram_we, ram_re;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  assign ram_we = in_fire && (in_ch.operation == OP_LOAD) &&
                  (int'(in_ch.row_index) < MAX_IMAGE_HEIGHT) &&
                  (int'(in_ch.col_index) < MAX_IMAGE_WIDTH);
  assign ram_waddr = {ROW_BITS'(in_ch.row_index), COL_BITS'(in_ch.col_index)};

  bfhr_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.integral_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Box geometry for the corner selected by the read counter.
  coord_t lq, lh, bq, wq, l2m1, r0, c0, nr, nc, rsel, csel, eh, ew, rc, cc;
  logic   [7:0] b_val;
  logic   [2:0] box_sel;
  logic   [1:0] corner_sel;
  logic         corner_zero;

  assign box_sel    = cnt_r[4:2];
  assign corner_sel = cnt_r[1:0];
  assign b_val = (filter_size_r == 8'd0) ? 8'd1 : (((filter_size_r - 8'd1) >> 1) + 8'd1);
  assign lq    = $signed({{(CW-8){1'b0}}, lobe_r});
  assign lh    = $signed({{(CW-8){1'b0}}, half_r});
  assign bq    = $signed({{(CW-8){1'b0}}, b_val});
  assign wq    = $signed({{(CW-8){1'b0}}, filter_size_r});
  assign l2m1  = (lq <<< 1) - coord_t'(1);
  assign eh    = ($signed({{(CW-9){1'b0}}, image_height_r}) > coord_t'(MAX_IMAGE_HEIGHT)) ?
                 coord_t'(MAX_IMAGE_HEIGHT) : $signed({{(CW-9){1'b0}}, image_height_r});
  assign ew    = ($signed({{(CW-9){1'b0}}, image_width_r}) > coord_t'(MAX_IMAGE_WIDTH)) ?
                 coord_t'(MAX_IMAGE_WIDTH) : $signed({{(CW-9){1'b0}}, image_width_r});

  always_comb begin
    case (box_sel)
      3'd0: begin
        r0 = pos_r_r - lq + coord_t'(1); c0 = pos_c_r - bq; nr = l2m1; nc = wq;
      end
      3'd1: begin
        r0 = pos_r_r - lq + coord_t'(1); c0 = pos_c_r - lh; nr = l2m1; nc = lq;
      end
      3'd2: begin
        r0 = pos_r_r - bq; c0 = pos_c_r - lq + coord_t'(1); nr = wq; nc = l2m1;
      end
      3'd3: begin
        r0 = pos_r_r - lh; c0 = pos_c_r - lq + coord_t'(1); nr = lq; nc = l2m1;
      end
      3'd4: begin r0 = pos_r_r - lq; c0 = pos_c_r + coord_t'(1); nr = lq; nc = lq; end
      3'd5: begin r0 = pos_r_r + coord_t'(1); c0 = pos_c_r - lq; nr = lq; nc = lq; end
      3'd6: begin r0 = pos_r_r - lq; c0 = pos_c_r - lq; nr = lq; nc = lq; end
      default: begin
        r0 = pos_r_r + coord_t'(1); c0 = pos_c_r + coord_t'(1); nr = lq; nc = lq;
      end
    endcase
    rsel = corner_sel[1] ? (r0 + nr) : r0;
    csel = corner_sel[0] ? (c0 + nc) : c0;
    rc   = ((rsel < eh) ? rsel : eh) - coord_t'(1);
    cc   = ((csel < ew) ? csel : ew) - coord_t'(1);
  end

  assign corner_zero = rc[CW-1] || cc[CW-1];
  assign ram_raddr   = {rc[ROW_BITS-1:0], cc[COL_BITS-1:0]};
  assign ram_re      = (state_r == S_READ) && (cnt_r < RCNT_W'(READS));

  // Corner accumulation as read data returns.
  logic signed [BW-1:0] term, box_sum, box_clip;
  logic signed [DW-1:0] box_one, box_three;

  always_comb begin
    term = p_zero_r ? '0 : $signed({{(BW-WORD_W){1'b0}}, ram_rdata});
    if (p_corner_r == 2'd1 || p_corner_r == 2'd2) begin
      term = -term;
    end
    box_sum   = ((p_corner_r == 2'd0) ? '0 : box_acc_r) + term;
    box_clip  = box_sum[BW-1] ? '0 : box_sum;
    box_one   = DW'(box_clip);
    box_three = (box_one <<< 1) + box_one;
  end

  // Shared multiplier for Dxx*Dyy and Dxy*Dxy.
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  assign mul_a = (state_r == S_MUL_A) ? dxx_r : dxy_r;
  assign mul_b = (state_r == S_MUL_A) ? dyy_r : dxy_r;
  assign mul_p = mul_a * mul_b;

  // Numerator, magnitude and divider step.
  logic signed [NW-1:0] pa_x, pb_x, num;
  logic [NW-1:0]        mag;
  logic [DENW-1:0]      w4_x, rem_sh;
  logic                 div_ge;
  logic                 q_hi;

  assign pa_x   = NW'(pa_r);
  assign pb_x   = NW'(pb_r);
  assign w4_x   = DENW'(w4_r);
  assign num    = t1_r - t2_r;
  assign mag    = num[NW-1] ? (NW'(0) - num) : num;
  assign rem_sh = {rem_r[DENW-2:0], dvd_r[QW-1]};
  assign div_ge = rem_sh >= den_r;
  assign q_hi   = |dvd_r[QW-1:RESP_W];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire && in_ch.operation == OP_COMPUTE) state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_READ;
      S_READ:  if (cnt_r == RCNT_W'(READS)) state_nxt = S_MUL_A;
      S_MUL_A: state_nxt = S_MUL_B;
      S_MUL_B: state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_NUM;
      S_NUM:   state_nxt = (den_r == '0) ? S_DONE : S_DIV;
      S_DIV:   if (dcnt_r == DCNT_W'(QW - 1)) state_nxt = S_SAT;
      S_SAT:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control counters and read pipeline flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      dcnt_r    <= '0;
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= ram_re;
      if (state_r == S_SETUP) begin
        cnt_r <= '0;
      end else if (state_r == S_READ) begin
        cnt_r <= cnt_r + RCNT_W'(1);
      end
      if (state_r == S_NUM) begin
        dcnt_r <= '0;
      end else if (state_r == S_DIV) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r <= in_ch.row_index;
      col_r <= in_ch.col_index;
    end
    p_zero_r   <= corner_zero;
    p_box_r    <= box_sel;
    p_corner_r <= corner_sel;
    case (state_r)
      S_SETUP: begin
        pos_r_r <= $signed({{(CW-14){1'b0}}, 14'(row_r) * 14'(sample_step_r)});
        pos_c_r <= $signed({{(CW-14){1'b0}}, 14'(col_r) * 14'(sample_step_r)});
        lobe_r  <= 8'((17'(filter_size_r) * 17'd171) >> 9);
        half_r  <= 8'((17'(filter_size_r) * 17'd171) >> 10);
        w2_r    <= 16'(filter_size_r) * 16'(filter_size_r);
        dxx_r   <= '0;
        dyy_r   <= '0;
        dxy_r   <= '0;
      end
      S_MUL_A: begin
        pa_r  <= mul_p;
        w4_r  <= 32'(w2_r) * 32'(w2_r);
        lap_r <= !((DW+1)'(dxx_r) + (DW+1)'(dyy_r) < 0);
      end
      S_MUL_B: pb_r <= mul_p;
      S_SCALE: begin
        t1_r  <= (pa_x <<< 6) + (pa_x <<< 5) + (pa_x <<< 2);
        t2_r  <= (pb_x <<< 6) + (pb_x <<< 4) + pb_x;
        den_r <= (w4_x << 6) + (w4_x << 5) + (w4_x << 2);
      end
      S_NUM: begin
        neg_r <= num[NW-1];
        dvd_r <= {mag, 16'd0} + QW'(den_r >> 1);
        rem_r <= '0;
        res_r <= '0;
      end
      S_DIV: begin
        rem_r <= div_ge ? (rem_sh - den_r) : rem_sh;
        dvd_r <= {dvd_r[QW-2:0], div_ge};
      end
      S_SAT: begin
        if (!neg_r) begin
          res_r <= (q_hi || dvd_r[RESP_W-1]) ? RESP_MAX : dvd_r[RESP_W-1:0];
        end else if (q_hi || (dvd_r[RESP_W-1] && |dvd_r[RESP_W-2:0])) begin
          res_r <= RESP_MIN;
        end else begin
          res_r <= RESP_W'(0) - dvd_r[RESP_W-1:0];
        end
      end
      default: ;
    endcase
    // Fold each finished box into its Hessian term.
    if (p_valid_r) begin
      box_acc_r <= box_sum;
      if (p_corner_r == 2'd3) begin
        case (p_box_r)
          3'd0:         dxx_r <= dxx_r + box_one;
          3'd1:         dxx_r <= dxx_r - box_three;
          3'd2:         dyy_r <= dyy_r + box_one;
          3'd3:         dyy_r <= dyy_r - box_three;
          3'd4, 3'd5:   dxy_r <= dxy_r + box_one;
          default:      dxy_r <= dxy_r - box_one;
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_resp_r <= res_r;
      out_lap_r  <= lap_r;
    end
  end

`ifndef SYNTHESIS
  a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> cnt_r <= RCNT_W'(READS))
    else $error("read counter ran past the last corner");

  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> den_r != '0)
    else $error("divider running with a zero denominator");

  a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.operation == OP_LOAD |=> state_r == S_IDLE)
    else $error("load transaction left the idle state");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result was not presented");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_box_filter_hessian_response_core.sv
`timescale 1ns / 1ps

module tb_box_filter_hessian_response_core;
  import bfhr_pkg::*;

  typedef struct {
    logic [47:0] response;
    logic        laplacian_sign;
  } hessian_result_t;

  localparam longint RESP_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint RESP_LO = -64'sh0000_8000_0000_0000;
  localparam int SETTLE_CYCLES = 150;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bfhr_in_if  in_ch();
  bfhr_out_if out_ch();

  box_filter_hessian_response_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the block's registers and integral image.
  int unsigned filt_size;
  int unsigned samp_step;
  int unsigned img_w;
  int unsigned img_h;
  logic [23:0] image_words [STORE_DEPTH];
  bit          word_written [STORE_DEPTH];

  hessian_result_t pending_results[$];
  int error_count;
  int burst_left;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Report one mismatch and count it.
  task automatic report_mismatch(input string what, input logic [47:0] exp_v,
                                 input logic [47:0] got_v);
    $display("[%0t] mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
    error_count++;
  endtask

  function automatic int min_int(input int a, input int b);
    return a < b ? a : b;
  endfunction

  function automatic longint corner_word(input int r, input int c);
    if (r < 0 || c < 0) return 0;
    return longint'(image_words[r * MAX_IMAGE_WIDTH + c]);
  endfunction

  // Clamped box integral, clipped at zero.
  function automatic longint box_sum(input int row, input int col, input int rows,
                                     input int cols);
    int h;
    int w;
    int r1;
    int c1;
    int r2;
    int c2;
    longint v;
    h = (img_h > MAX_IMAGE_HEIGHT) ? MAX_IMAGE_HEIGHT : int'(img_h);
    w = (img_w > MAX_IMAGE_WIDTH) ? MAX_IMAGE_WIDTH : int'(img_w);
    r1 = min_int(row, h) - 1;
    c1 = min_int(col, w) - 1;
    r2 = min_int(row + rows, h) - 1;
    c2 = min_int(col + cols, w) - 1;
    v = corner_word(r1, c1) - corner_word(r1, c2) - corner_word(r2, c1)
        + corner_word(r2, c2);
    return v < 0 ? 0 : v;
  endfunction

  // Determinant of Hessian and Laplacian sign at one layer sample.
  function automatic hessian_result_t hessian_at(input logic [7:0] row_s,
                                                 input logic [7:0] col_s);
    hessian_result_t res;
    int w;
    int l;
    int b;
    int r;
    int c;
    longint dxx;
    longint dyy;
    longint dxy;
    longint num;
    longint rs;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    longint unsigned rem;
    longint unsigned frac;
    bit neg;
    w = int'(filt_size);
    l = w / 3;
    b = (w - 1) / 2 + 1;
    r = int'(row_s) * int'(samp_step);
    c = int'(col_s) * int'(samp_step);
    dxx = box_sum(r - l + 1, c - b, 2 * l - 1, w)
          - box_sum(r - l + 1, c - l / 2, 2 * l - 1, l) * 3;
    dyy = box_sum(r - b, c - l + 1, w, 2 * l - 1)
          - box_sum(r - l / 2, c - l + 1, l, 2 * l - 1) * 3;
    dxy = box_sum(r - l, c + 1, l, l) + box_sum(r + 1, c - l, l, l)
          - box_sum(r - l, c - l, l, l) - box_sum(r + 1, c + 1, l, l);
    rs = 0;
    if (w > 0) begin
      num = 64'sd100 * dxx * dyy - 64'sd81 * dxy * dxy;
      neg = num < 0;
      mag = neg ? longint'(-num) : longint'(num);
      den = longint'(w) * longint'(w);
      den = den * den * 100;
      q = mag / den;
      rem = mag % den;
      if (q >= (64'd1 << 31)) begin
        rs = neg ? RESP_LO : RESP_HI;
      end else begin
        frac = (rem * 65536 + den / 2) / den;
        mag = q * 65536 + frac;
        if (neg) begin
          rs = (mag > 64'h0000_8000_0000_0000) ? RESP_LO : -longint'(mag);
        end else begin
          rs = (mag > 64'h0000_7FFF_FFFF_FFFF) ? RESP_HI : longint'(mag);
        end
      end
    end
    res.response = rs[47:0];
    res.laplacian_sign = (dxx + dyy >= 0);
    return res;
  endfunction

  // Send one transaction; the caller stands at a rising edge.
  task automatic send_item(input logic op, input logic [7:0] row, input logic [7:0] col,
                           input logic [23:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.row_index <= row;
    in_ch.col_index <= col;
    in_ch.integral_value <= word;
    do @(posedge clk); while (!in_ch.ready);
    // Accepted at this edge: update the mirror in order.
    if (op == OP_LOAD) begin
      image_words[{row, col}] = word;
      word_written[{row, col}] = 1'b1;
    end else begin
      pending_results.insert(pending_results.size(), hessian_at(row, col));
    end
  endtask

  // Let all outstanding work finish, then let the block settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FILTER_SIZE:  filt_size = value & 32'hFF;
      CFG_SAMPLE_STEP:  samp_step = value & 32'h3F;
      CFG_IMAGE_WIDTH:  img_w = value & 32'h1FF;
      CFG_IMAGE_HEIGHT: img_h = value & 32'h1FF;
      default: ;
    endcase
  endtask

  function automatic logic [23:0] random_word();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 255));
      1: return 24'hFFFFFF;
      2: return 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Load every unwritten word of the region that computes may read.
  task automatic fill_region(input int h, input int w);
    for (int rr = 0; rr < min_int(h, MAX_IMAGE_HEIGHT); rr++) begin
      for (int cc = 0; cc < min_int(w, MAX_IMAGE_WIDTH); cc++) begin
        if (!word_written[rr * MAX_IMAGE_WIDTH + cc]) begin
          send_item(OP_LOAD, rr[7:0], cc[7:0], random_word());
        end
      end
    end
  endtask

  task automatic compute_at(input int row, input int col);
    send_item(OP_COMPUTE, row[7:0], col[7:0], 24'($urandom));
  endtask

  // Result checking and receiver stall pattern.
  int stall_left;
  int mode_left;
  int stall_mode;
  always @(posedge clk) begin
    hessian_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      mode_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 48'h0, out_ch.response);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_ch.response !== exp_r.response)
            report_mismatch("response", exp_r.response, out_ch.response);
          if (out_ch.laplacian_sign !== exp_r.laplacian_sign)
            report_mismatch("laplacian_sign", 48'(exp_r.laplacian_sign),
                            48'(out_ch.laplacian_sign));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        case (stall_mode)
          1: if ($urandom_range(0, 1) == 1) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 40);
          default: ;
        endcase
      end
    end
  end

  // Full-width row with a one-row image, then the width clamped above the store.
  task automatic test_wide_strip();
    write_reg(CFG_IMAGE_HEIGHT, 1);
    fill_region(1, 256);
    send_item(OP_LOAD, 8'd0, 8'd0, 24'hFFFFFF);
    send_item(OP_LOAD, 8'd0, 8'd255, 24'h000000);
    compute_at(0, 0);
    compute_at(1, 128);
    compute_at(255, 255);
    compute_at(0, 255);
    write_reg(CFG_IMAGE_WIDTH, 511);
    compute_at(1, 127);
    compute_at(0, 254);
  endtask

  // One-column image with all rows, then the height clamped above the store.
  task automatic test_tall_strip();
    write_reg(CFG_IMAGE_WIDTH, 1);
    write_reg(CFG_IMAGE_HEIGHT, 256);
    fill_region(256, 1);
    compute_at(128, 1);
    compute_at(255, 0);
    write_reg(CFG_IMAGE_HEIGHT, 511);
    compute_at(100, 1);
  endtask

  // Zero and extreme register settings.
  task automatic test_register_extremes();
    write_reg(CFG_IMAGE_WIDTH, 16);
    write_reg(CFG_IMAGE_HEIGHT, 16);
    fill_region(16, 16);
    write_reg(CFG_FILTER_SIZE, 0);
    compute_at(4, 4);
    write_reg(CFG_FILTER_SIZE, 255);
    compute_at(3, 3);
    write_reg(CFG_FILTER_SIZE, 195);
    write_reg(CFG_SAMPLE_STEP, 48);
    compute_at(0, 0);
    compute_at(1, 1);
    write_reg(CFG_FILTER_SIZE, 9);
    write_reg(CFG_SAMPLE_STEP, 0);
    compute_at(9, 9);
    write_reg(CFG_SAMPLE_STEP, 63);
    compute_at(0, 0);
    write_reg(CFG_SAMPLE_STEP, 1);
    write_reg(CFG_IMAGE_WIDTH, 0);
    compute_at(5, 5);
    write_reg(CFG_IMAGE_WIDTH, 16);
    write_reg(CFG_IMAGE_HEIGHT, 0);
    compute_at(5, 5);
    write_reg(CFG_IMAGE_HEIGHT, 1);
    write_reg(CFG_IMAGE_WIDTH, 1);
    compute_at(0, 0);
  endtask

  // Random phases: small images, random settings, mostly computes inside the image.
  task automatic test_random_phases();
    int h;
    int w;
    int span_r;
    int span_c;
    int step_div;
    int items;
    items = 0;
    while (items < 880) begin
      h = $urandom_range(1, 16);
      w = $urandom_range(1, 16);
      write_reg(CFG_IMAGE_HEIGHT, h);
      write_reg(CFG_IMAGE_WIDTH, w);
      case ($urandom_range(0, 3))
        0: write_reg(CFG_FILTER_SIZE, $urandom_range(0, 511));
        1: write_reg(CFG_FILTER_SIZE, 9);
        default: write_reg(CFG_FILTER_SIZE, 9 + 6 * $urandom_range(0, 31));
      endcase
      if ($urandom_range(0, 4) == 0) write_reg(CFG_SAMPLE_STEP, $urandom_range(0, 63));
      else write_reg(CFG_SAMPLE_STEP, $urandom_range(1, 4));
      fill_region(h, w);
      step_div = (samp_step == 0) ? 1 : int'(samp_step);
      span_r = min_int(h / step_div + 2, 255);
      span_c = min_int(w / step_div + 2, 255);
      repeat (80) begin
        case ($urandom_range(0, 9))
          0: compute_at($urandom_range(0, 255), $urandom_range(0, 255));
          1, 2: send_item(OP_LOAD, 8'($urandom_range(0, h - 1)),
                          8'($urandom_range(0, w - 1)), random_word());
          3: send_item(OP_LOAD, 8'($urandom), 8'($urandom), 24'($urandom));
          default: compute_at($urandom_range(0, span_r), $urandom_range(0, span_c));
        endcase
        items++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    error_count = 0;
    burst_left = 0;
    filt_size = 9;
    samp_step = 2;
    img_w = 256;
    img_h = 256;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_LOAD;
    in_ch.row_index <= '0;
    in_ch.col_index <= '0;
    in_ch.integral_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_wide_strip();
    test_tall_strip();
    test_register_extremes();
    test_random_phases();
    wait_idle();

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
